>>> hw/rtl/twcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcr_pkg
// Shared types and constants for the thresholded window region finder.
// ----------------------------------------------------------------------------
package twcr_pkg;

  localparam int HALF_WINDOW_DEF   = 30;
  localparam int POSITION_BITS_DEF = 28;
  localparam int COUNT_BITS_DEF    = 16;

  localparam int SCORE_BITS     = 32;
  localparam int BIN_COUNT_BITS = 16;
  localparam int SUM_BITS       = 22;
  localparam int OUT_POS_BITS   = 28;
  localparam int IN_DATA_BITS   = 48;
  localparam int OUT_DATA_BITS  = 112;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_FL_RD,
    ST_FL_USE,
    ST_FL_END
  } state_t;

  typedef struct packed {
    logic                           region_valid;
    logic [OUT_POS_BITS-1:0]        region_start;
    logic [OUT_POS_BITS-1:0]        region_end;
    logic signed [SCORE_BITS-1:0]   region_score;
    logic [SUM_BITS-1:0]            window_count;
  } result_t;

endpackage

>>> hw/rtl/twcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 61
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/thresholded_window_count_regions_top.sv
`timescale 1ns / 1ps
// A region is loaded into the output register in the RMW state after its end
// bin is accepted, waiting while that register is full. A bin is taken only when
// idle, after the previous one is read from the rings, modified and written back.
// The last bin walks up to HALF_WINDOW pending centers through the ring memories, then gives the final result.
// Reset (rst, synchronous) clears control, sum, position and threshold; the
// ring memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// thresholded_window_count_regions_top
// Sliding-window count sum with thresholded region reporting per bin.
// ----------------------------------------------------------------------------
module thresholded_window_count_regions_top #(
  parameter int HALF_WINDOW   = twcr_pkg::HALF_WINDOW_DEF,
  parameter int POSITION_BITS = twcr_pkg::POSITION_BITS_DEF,
  parameter int COUNT_BITS    = twcr_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // threshold write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [twcr_pkg::SCORE_BITS-1:0]     cfg_data,
  // bins
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] bin_score, [47:32] bin_count
  input  logic [twcr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  input  logic                                s_axis_tlast,   // last_bin
  // regions
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [27:0] region_start, [55:28] region_end, [87:56] region_score,
  // [109:88] window_count, [111:110] zero
  output logic [twcr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  output logic                                m_axis_tuser,   // region_valid
  output logic                                m_axis_tlast    // run_last
);

  localparam int CD        = 2 * HALF_WINDOW + 1;
  localparam int SD        = HALF_WINDOW + 1;
  localparam int CSLOT_W   = $clog2(CD);
  localparam int SSLOT_W   = $clog2(SD);
  localparam int SUM_W     = twcr_pkg::SUM_BITS;
  localparam int SC_W      = twcr_pkg::SCORE_BITS;
  localparam int OP_W      = twcr_pkg::OUT_POS_BITS;
  localparam int BIN_EXT_W = twcr_pkg::BIN_COUNT_BITS + COUNT_BITS;

  localparam logic [POSITION_BITS-1:0] P_H   = POSITION_BITS'(HALF_WINDOW);
  localparam logic [POSITION_BITS-1:0] P_HM1 = POSITION_BITS'(HALF_WINDOW - 1);
  localparam logic [POSITION_BITS-1:0] P_HP1 = POSITION_BITS'(HALF_WINDOW + 1);
  localparam logic [POSITION_BITS-1:0] P_2H  = POSITION_BITS'(2 * HALF_WINDOW);
  localparam logic [POSITION_BITS-1:0] P_CD  = POSITION_BITS'(CD);
  localparam logic [CSLOT_W-1:0]       C_LAST = CSLOT_W'(CD - 1);
  localparam logic [SSLOT_W-1:0]       S_LAST = SSLOT_W'(SD - 1);

  function automatic logic [CSLOT_W-1:0] cinc(input logic [CSLOT_W-1:0] v);
    return (v == C_LAST) ? '0 : v + CSLOT_W'(1);
  endfunction

  function automatic logic [SSLOT_W-1:0] sinc(input logic [SSLOT_W-1:0] v);
    return (v == S_LAST) ? '0 : v + SSLOT_W'(1);
  endfunction

  function automatic logic [OP_W-1:0] to_out_pos(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+OP_W-1:0] e;
    e = {{OP_W{1'b0}}, v};
    return e[OP_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] to_sum(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+SUM_W-1:0] e;
    e = {{SUM_W{1'b0}}, v};
    return e[SUM_W-1:0];
  endfunction

  // control and state registers
  twcr_pkg::state_t           state, state_next;
  logic [POSITION_BITS-1:0]   pos;
  logic [CSLOT_W-1:0]         cslot;
  logic [SSLOT_W-1:0]         sslot;
  logic [SUM_W-1:0]           running_sum;
  logic signed [SC_W-1:0]     threshold;

  // request being processed
  logic [SC_W-1:0]            in_score;
  logic [COUNT_BITS-1:0]      in_count;
  logic                       in_last;

  // flush walk
  logic [POSITION_BITS-1:0]   fc;
  logic [SSLOT_W-1:0]         fs_slot;
  logic [CSLOT_W-1:0]         fj_slot;
  logic [SUM_W-1:0]           fw;

  // held result (last bin only) and output register
  logic                       held_v;
  twcr_pkg::result_t          held;
  logic                       out_v;
  twcr_pkg::result_t          out_res;
  logic                       out_last;

  // memory ports
  logic                       mem_re;
  logic                       mem_we;
  logic [CSLOT_W-1:0]         c_raddr;
  logic [SSLOT_W-1:0]         s_raddr;
  logic [COUNT_BITS-1:0]      c_rdata;
  logic [SC_W-1:0]            s_rdata;

  // datapath
  logic                       in_accept;
  logic                       out_free;
  logic                       out_load;
  logic                       go;
  logic [COUNT_BITS-1:0]      bin_count_m;
  logic [BIN_EXT_W-1:0]       bin_count_ext;
  logic [SUM_W-1:0]           sum_new;
  logic                       passes;
  logic                       rmw_hit;
  twcr_pkg::result_t          rmw_res;
  logic [POSITION_BITS-1:0]   c0;
  logic                       fl_sub;
  logic [SUM_W-1:0]           fw_new;
  twcr_pkg::result_t          fl_res;
  twcr_pkg::result_t          marker;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == twcr_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v || m_axis_tready;

  assign bin_count_ext = {{COUNT_BITS{1'b0}}, s_axis_tdata[47:32]};
  assign bin_count_m   = bin_count_ext[COUNT_BITS-1:0];

  assign passes = $signed(s_rdata) > threshold;

  // new window sum for the bin in flight
  always_comb begin
    sum_new = running_sum + to_sum(in_count);
    if (pos >= P_CD) begin
      sum_new = sum_new - to_sum(c_rdata);
    end
  end

  // region whose end bin is the current bin
  assign rmw_hit = (pos >= P_H) && passes;
  always_comb begin
    rmw_res.region_valid = 1'b1;
    rmw_res.region_start = (pos >= P_2H) ? to_out_pos(pos - P_2H) : '0;
    rmw_res.region_end   = to_out_pos(pos);
    rmw_res.region_score = $signed(s_rdata);
    rmw_res.window_count = sum_new;
  end

  assign c0 = (pos >= P_HM1) ? pos - P_HM1 : '0;

  // flush step for center fc
  assign fl_sub = (fc >= P_HP1);
  assign fw_new = fl_sub ? fw - to_sum(c_rdata) : fw;
  always_comb begin
    fl_res.region_valid = 1'b1;
    fl_res.region_start = (fc >= P_H) ? to_out_pos(fc - P_H) : '0;
    fl_res.region_end   = to_out_pos(pos);
    fl_res.region_score = $signed(s_rdata);
    fl_res.window_count = fw_new;
  end

  assign marker = '0;

  // load the output register with a fresh region or the final result
  assign out_load = ((state == twcr_pkg::ST_RMW) && go && !in_last && rmw_hit) ||
                    ((state == twcr_pkg::ST_FL_USE) && go && passes && held_v) ||
                    ((state == twcr_pkg::ST_FL_END) && go);

  // next state and memory control
  always_comb begin
    state_next = state;
    go         = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    c_raddr    = cslot;
    s_raddr    = sinc(sslot);
    unique case (state)
      twcr_pkg::ST_IDLE: begin
        mem_re = in_accept;
        if (in_accept) begin
          state_next = twcr_pkg::ST_RMW;
        end
      end
      twcr_pkg::ST_RMW: begin
        go     = in_last || !rmw_hit || out_free;
        mem_we = go;
        if (go) begin
          state_next = in_last ? twcr_pkg::ST_FL_RD : twcr_pkg::ST_IDLE;
        end
      end
      twcr_pkg::ST_FL_RD: begin
        mem_re     = 1'b1;
        c_raddr    = fj_slot;
        s_raddr    = fs_slot;
        state_next = twcr_pkg::ST_FL_USE;
      end
      twcr_pkg::ST_FL_USE: begin
        go = !(passes && held_v && !out_free);
        if (go) begin
          state_next = (fc == pos) ? twcr_pkg::ST_FL_END : twcr_pkg::ST_FL_RD;
        end
      end
      twcr_pkg::ST_FL_END: begin
        go = out_free;
        if (go) begin
          state_next = twcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = twcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= $signed(cfg_data);
    end
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_score <= s_axis_tdata[31:0];
      in_count <= bin_count_m;
      in_last  <= s_axis_tlast;
    end
  end

  // position, slots, sum, held result, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      cslot       <= '0;
      sslot       <= '0;
      running_sum <= '0;
      held_v      <= 1'b0;
      out_v       <= 1'b0;
    end else begin
      if (out_load) begin
        out_v <= 1'b1;
      end else if (m_axis_tready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        twcr_pkg::ST_RMW: begin
          if (go) begin
            running_sum <= sum_new;
            if (in_last) begin
              held_v  <= rmw_hit;
              fc      <= c0;
              fs_slot <= (pos >= P_HM1) ? sinc(sinc(sslot)) : '0;
              fj_slot <= (pos >= P_2H) ? cinc(cslot) : '0;
              fw      <= sum_new;
            end else begin
              if (rmw_hit) begin
                out_last <= 1'b0;
              end
              // advance; restart slot counters when the position wraps
              pos <= pos + POSITION_BITS'(1);
              if (pos == '1) begin
                cslot <= '0;
                sslot <= '0;
              end else begin
                cslot <= cinc(cslot);
                sslot <= sinc(sslot);
              end
            end
          end
        end
        twcr_pkg::ST_FL_USE: begin
          if (go) begin
            fw      <= fw_new;
            fc      <= fc + POSITION_BITS'(1);
            fs_slot <= sinc(fs_slot);
            if (fl_sub) begin
              fj_slot <= cinc(fj_slot);
            end
            if (passes) begin
              held_v <= 1'b1;
              if (held_v) begin
                out_last <= 1'b0;
              end
            end
          end
        end
        twcr_pkg::ST_FL_END: begin
          if (go) begin
            out_last    <= 1'b1;
            held_v      <= 1'b0;
            running_sum <= '0;
            pos         <= '0;
            cslot       <= '0;
            sslot       <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    unique case (state)
      twcr_pkg::ST_RMW: begin
        if (go) begin
          if (in_last) begin
            held <= rmw_res;
          end else if (rmw_hit) begin
            out_res <= rmw_res;
          end
        end
      end
      twcr_pkg::ST_FL_USE: begin
        if (go && passes) begin
          held <= fl_res;
          if (held_v) begin
            out_res <= held;
          end
        end
      end
      twcr_pkg::ST_FL_END: begin
        if (go) begin
          out_res <= held_v ? held : marker;
        end
      end
      default: begin
      end
    endcase
  end

  twcr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CD)
  ) u_count_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cslot),
    .wdata (in_count),
    .re    (mem_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  twcr_ram #(
    .WIDTH (SC_W),
    .DEPTH (SD)
  ) u_score_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (sslot),
    .wdata (in_score),
    .re    (mem_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = out_res.region_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_res.window_count, out_res.region_score,
                          out_res.region_end, out_res.region_start};

endmodule
